FILE: rtl/sfsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_pkg
// Shared types and constants of the sensor frame sync parser: frame lengths,
// the sync byte, the byte window and the decoded result fields.
// ----------------------------------------------------------------------------
package sfsp_pkg;

    localparam int DATA_LEN  = 23;
    localparam int TEST_LEN  = 10;
    localparam int TEST_BASE = DATA_LEN - TEST_LEN;
    localparam int NUM_WORDS = 10;
    localparam int CNT_W     = 5;

    localparam logic [7:0] SYNC_BYTE = 8'hB4;

    // Register codes for packet_kind
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_TEST = 1'b1;

    typedef logic [CNT_W-1:0] fill_cnt_t;

    // Window of received bytes, index 0 oldest, index DATA_LEN-1 newest
    typedef logic [DATA_LEN-1:0][7:0] window_t;

    typedef struct packed {
        logic signed [15:0] status_word;
        logic signed [15:0] u_speed;
        logic signed [15:0] v_speed;
        logic signed [15:0] w_speed;
        logic signed [15:0] sound_speed;
        logic signed [15:0] analog_one;
        logic signed [15:0] analog_two;
        logic signed [15:0] analog_three;
        logic signed [15:0] analog_four;
        logic signed [15:0] temperature;
        logic        [31:0] test_identifier;
        logic        [31:0] test_sequence;
    } frame_fields_t;

endpackage

FILE: rtl/sfsp_frame_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsp_frame_match
// Checks the newest frame-length bytes of the window for the sync header and,
// in data mode, the XOR checksum; decodes the little-endian result fields.
// ----------------------------------------------------------------------------
module sfsp_frame_match (
    input  sfsp_pkg::window_t       window,
    input  logic                    packet_kind,
    input  logic                    len_ok,
    output logic                    hit,
    output sfsp_pkg::frame_fields_t fields
);
    import sfsp_pkg::*;

    logic [DATA_LEN-2:0] xor_col;
    logic [7:0]          xor_sum;
    logic                hdr_data;
    logic                hdr_test;
    logic [NUM_WORDS-1:0][15:0] words;

    // Fold bytes 0..21 of the data frame, one bit column at a time
    always_comb
    begin
        xor_col = '0;
        xor_sum = '0;
        for (int b = 0; b < 8; b++)
        begin
            for (int i = 0; i < DATA_LEN - 1; i++)
            begin
                xor_col[i] = window[i][b];
            end
            xor_sum[b] = ^xor_col;
        end
    end

    // Check header of each frame position
    assign hdr_data = (window[0] == SYNC_BYTE) && (window[1] == SYNC_BYTE);
    assign hdr_test = (window[TEST_BASE] == SYNC_BYTE) &&
                      (window[TEST_BASE + 1] == SYNC_BYTE);

    always_comb
    begin
        if (packet_kind == KIND_TEST)
        begin
            hit = len_ok && hdr_test;
        end
        else
        begin
            hit = len_ok && hdr_data && (xor_sum == window[DATA_LEN - 1]);
        end
    end

    // Gather the ten little-endian 16-bit words of a data frame
    always_comb
    begin
        for (int k = 0; k < NUM_WORDS; k++)
        begin
            words[k] = {window[3 + 2 * k], window[2 + 2 * k]};
        end
    end

    // Decode fields; zero those of the other mode
    always_comb
    begin
        fields = '0;
        if (packet_kind == KIND_TEST)
        begin
            fields.test_identifier = {window[TEST_BASE + 5], window[TEST_BASE + 4],
                                      window[TEST_BASE + 3], window[TEST_BASE + 2]};
            fields.test_sequence   = {window[TEST_BASE + 9], window[TEST_BASE + 8],
                                      window[TEST_BASE + 7], window[TEST_BASE + 6]};
        end
        else
        begin
            fields.status_word  = words[0];
            fields.u_speed      = words[1];
            fields.v_speed      = words[2];
            fields.w_speed      = words[3];
            fields.sound_speed  = words[4];
            fields.analog_one   = words[5];
            fields.analog_two   = words[6];
            fields.analog_three = words[7];
            fields.analog_four  = words[8];
            fields.temperature  = words[9];
        end
    end

endmodule

FILE: rtl/sensor_frame_sync_parser.sv
`timescale 1ns / 1ps
// A frame's result is registered when the word that completes it is taken.
// Throughput: one word per cycle while in_ready is high; the window shift,
// header compare and XOR fold all sit between the window register and the
// result register. A pending result stalls input only while out_ready is low.
// Reset (rst_n, async, active low) clears the window, fill count,
// packet_kind (data mode) and the result valid flag.
// ----------------------------------------------------------------------------
// sensor_frame_sync_parser
// Sliding-window frame parser: finds sync-headed data or test frames in a
// received byte stream and emits the decoded fields of each valid frame.
// ----------------------------------------------------------------------------
module sensor_frame_sync_parser (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    // input word stream
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    // result stream
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] status_word,
    output logic signed [15:0] u_speed,
    output logic signed [15:0] v_speed,
    output logic signed [15:0] w_speed,
    output logic signed [15:0] sound_speed,
    output logic signed [15:0] analog_one,
    output logic signed [15:0] analog_two,
    output logic signed [15:0] analog_three,
    output logic signed [15:0] analog_four,
    output logic signed [15:0] temperature,
    output logic        [31:0] test_identifier,
    output logic        [31:0] test_sequence
);
    import sfsp_pkg::*;

    window_t       window_reg;
    window_t       window_next;
    fill_cnt_t     fill_reg;
    fill_cnt_t     fill_inc;
    fill_cnt_t     fill_next;
    logic          kind_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    frame_fields_t fields_reg;
    frame_fields_t match_fields;
    logic          len_ok;
    logic          hit;
    logic          take;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Shift the new word in at the newest end
    assign window_next = {rx_byte, window_reg[DATA_LEN-1:1]};

    // Advance fill count, saturating at the data frame length
    assign fill_inc = (fill_reg < CNT_W'(DATA_LEN)) ? fill_reg + 1'b1 : fill_reg;
    assign len_ok   = (kind_reg == KIND_TEST) ? (fill_inc >= CNT_W'(TEST_LEN))
                                              : (fill_inc >= CNT_W'(DATA_LEN));

    sfsp_frame_match u_match (
        .window      (window_next),
        .packet_kind (kind_reg),
        .len_ok      (len_ok),
        .hit         (hit),
        .fields      (match_fields)
    );

    // Clear the count on an accepted frame so the next one starts after it
    assign fill_next = hit ? '0 : fill_inc;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = hit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold window, count, mode and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            fill_reg      <= '0;
            kind_reg      <= KIND_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                kind_reg <= cfg_wr_data;
            end
            if (take)
            begin
                window_reg <= window_next;
                fill_reg   <= fill_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload on a matching word
    always_ff @(posedge clk)
    begin
        if (take && hit)
        begin
            fields_reg <= match_fields;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status_word     = fields_reg.status_word;
    assign u_speed         = fields_reg.u_speed;
    assign v_speed         = fields_reg.v_speed;
    assign w_speed         = fields_reg.w_speed;
    assign sound_speed     = fields_reg.sound_speed;
    assign analog_one      = fields_reg.analog_one;
    assign analog_two      = fields_reg.analog_two;
    assign analog_three    = fields_reg.analog_three;
    assign analog_four     = fields_reg.analog_four;
    assign temperature     = fields_reg.temperature;
    assign test_identifier = fields_reg.test_identifier;
    assign test_sequence   = fields_reg.test_sequence;

endmodule
